FILE: rtl/core/qcrc_pkg.sv
// Package for the quote/comment range classifier.
// Holds block geometry, register indexes, reset values and the pipeline stage type.
// No dependencies.
`default_nettype none

package qcrc_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned BYTE_W      = 8;
  // each resolve step retires at least two lanes, so half the lanes bounds the steps
  localparam int unsigned NUM_STEPS   = (BLOCK_BYTES + 1) / 2;
  // match stage + escape stage + resolve stages + output stage
  localparam int unsigned LATENCY     = NUM_STEPS + 3;

  typedef logic [BLOCK_BYTES-1:0] lane_t;

  localparam lane_t EVEN_LANES = lane_t'(16'h5555);
  localparam lane_t TOP_LANE   = lane_t'(1) << (BLOCK_BYTES - 1);

  typedef enum logic [1:0] {
    CFG_ESCAPE  = 2'd0,
    CFG_QUOTE   = 2'd1,
    CFG_COMMENT = 2'd2,
    CFG_NEWLINE = 2'd3
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] ESCAPE_RST  = 8'd92;
  localparam logic [BYTE_W-1:0] QUOTE_RST   = 8'd34;
  localparam logic [BYTE_W-1:0] COMMENT_RST = 8'd59;
  localparam logic [BYTE_W-1:0] NEWLINE_RST = 8'd10;

  // one item in flight through the range resolver
  typedef struct packed {
    lane_t esc;
    lane_t quotes;
    lane_t comments;
    lane_t newlines;
    lane_t q;       // quotes still open for resolution
    lane_t c;       // comment starts still open
    lane_t nl;      // newlines not yet consumed
    lane_t bounds;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/core/quote_comment_range_classifier.sv
// Quote/comment range classifier top level: 16-byte block in, six lane masks out.
// Accepts one item per cycle and marks each result with done_o; busy_o is always low.
// Eight resolve stages each retire one opener; the output stage forms the prefix xor.
// Reset clears the valid pipeline and loads the default character registers.
// Results are shown for one cycle under done_o; the receiver cannot stall.
// Depends on qcrc_pkg.
`default_nettype none

module quote_comment_range_classifier (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] bytes_low_i,
  input  wire logic [63:0] bytes_high_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  output logic             done_o,
  output logic [15:0]      escaped_mask_o,
  output logic [15:0]      quote_mask_o,
  output logic [15:0]      comment_mask_o,
  output logic [15:0]      newline_mask_o,
  output logic [15:0]      bound_mask_o,
  output logic [15:0]      inside_mask_o
);

  localparam int unsigned NS = qcrc_pkg::NUM_STEPS;

  function automatic qcrc_pkg::lane_t low_bit(input qcrc_pkg::lane_t m);
    return m & (~m + qcrc_pkg::lane_t'(1));
  endfunction

  // one iteration of the earliest-opener loop
  function automatic qcrc_pkg::stage_t resolve_step(input qcrc_pkg::stage_t s);
    qcrc_pkg::stage_t r;
    qcrc_pkg::lane_t  lq, lc, lo, hi, qn, keep;
    r  = s;
    lq = low_bit(s.q);
    lc = low_bit(s.c);
    qn = s.q;
    if ((lq != '0) && ((lc == '0) || (lq < lc))) begin
      lo = lq;
      qn = s.q & ~lo;
      hi = low_bit(qn);
    end else begin
      lo = lc;
      // newlines at or below the comment start are skipped
      hi = low_bit(s.nl & ~((lo << 1) - qcrc_pkg::lane_t'(1)));
    end
    if (hi == '0) begin
      hi = qcrc_pkg::TOP_LANE;
    end
    keep = ~((hi << 1) - qcrc_pkg::lane_t'(1));
    if ((s.q != '0) || (s.c != '0)) begin
      r.bounds = s.bounds | hi | lo;
      r.q      = qn & keep;
      r.c      = s.c & keep;
      r.nl     = s.nl & keep;
    end
    return r;
  endfunction

  // character registers
  logic [7:0] esc_ch_q, quo_ch_q, com_ch_q, nl_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_ch_q <= qcrc_pkg::ESCAPE_RST;
      quo_ch_q <= qcrc_pkg::QUOTE_RST;
      com_ch_q <= qcrc_pkg::COMMENT_RST;
      nl_ch_q  <= qcrc_pkg::NEWLINE_RST;
    end else if (cfg_we_i) begin
      case (qcrc_pkg::cfg_idx_e'(cfg_idx_i))
        qcrc_pkg::CFG_ESCAPE:  esc_ch_q <= cfg_data_i;
        qcrc_pkg::CFG_QUOTE:   quo_ch_q <= cfg_data_i;
        qcrc_pkg::CFG_COMMENT: com_ch_q <= cfg_data_i;
        qcrc_pkg::CFG_NEWLINE: nl_ch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid bits travel alongside the data
  logic [qcrc_pkg::LATENCY-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[qcrc_pkg::LATENCY-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: byte compares
  logic [127:0]    blk;
  qcrc_pkg::lane_t esc_m_d, quo_m_d, com_m_d, nl_m_d;
  qcrc_pkg::lane_t esc_m_q, quo_m_q, com_m_q, nl_m_q;

  assign blk = {bytes_high_i, bytes_low_i};

  always_comb begin
    for (int i = 0; i < qcrc_pkg::BLOCK_BYTES; i++) begin
      esc_m_d[i] = (blk[8*i +: 8] == esc_ch_q);
      quo_m_d[i] = (blk[8*i +: 8] == quo_ch_q);
      com_m_d[i] = (blk[8*i +: 8] == com_ch_q);
      nl_m_d[i]  = (blk[8*i +: 8] == nl_ch_q);
    end
  end

  always_ff @(posedge clk_i) begin
    esc_m_q <= esc_m_d;
    quo_m_q <= quo_m_d;
    com_m_q <= com_m_d;
    nl_m_q  <= nl_m_d;
  end

  // stage 2: odd escape runs via carry from even and odd run starts
  qcrc_pkg::lane_t  run_st, ev_st, od_st, od1, od2, esc_v;
  qcrc_pkg::stage_t st0_d;
  qcrc_pkg::stage_t st_d [1:NS];
  qcrc_pkg::stage_t st_q [NS+1];

  always_comb begin
    run_st = esc_m_q & ~(esc_m_q << 1);
    ev_st  = run_st & qcrc_pkg::EVEN_LANES;
    od_st  = run_st & ~qcrc_pkg::EVEN_LANES;
    od1    = (esc_m_q + ev_st) & ~esc_m_q & ~qcrc_pkg::EVEN_LANES;
    od2    = (esc_m_q + od_st) & ~esc_m_q & qcrc_pkg::EVEN_LANES;
    esc_v  = od1 | od2;

    st0_d.esc      = esc_v;
    st0_d.quotes   = quo_m_q & ~esc_v;
    st0_d.comments = com_m_q & ~esc_v;
    st0_d.newlines = nl_m_q;
    st0_d.q        = quo_m_q & ~esc_v;
    st0_d.c        = com_m_q & ~esc_v;
    st0_d.nl       = nl_m_q;
    st0_d.bounds   = '0;
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st0_d;
  end

  // resolve stages
  for (genvar k = 0; k < NS; k++) begin : g_res
    assign st_d[k+1] = resolve_step(st_q[k]);

    always_ff @(posedge clk_i) begin
      st_q[k+1] <= st_d[k+1];
    end
  end

  // output stage: inclusive prefix xor of the bounds
  qcrc_pkg::lane_t inside_d;

  always_comb begin
    for (int i = 0; i < qcrc_pkg::BLOCK_BYTES; i++) begin
      inside_d[i] = ^(st_q[NS].bounds & ~(~qcrc_pkg::lane_t'(0) << (i + 1)));
    end
  end

  always_ff @(posedge clk_i) begin
    escaped_mask_o <= qcrc_pkg::OUT_W'(st_q[NS].esc);
    quote_mask_o   <= qcrc_pkg::OUT_W'(st_q[NS].quotes);
    comment_mask_o <= qcrc_pkg::OUT_W'(st_q[NS].comments);
    newline_mask_o <= qcrc_pkg::OUT_W'(st_q[NS].newlines);
    bound_mask_o   <= qcrc_pkg::OUT_W'(st_q[NS].bounds);
    inside_mask_o  <= qcrc_pkg::OUT_W'(inside_d);
  end

  assign done_o = vld_q[qcrc_pkg::LATENCY-1];

endmodule

`default_nettype wire

FILE: rtl/core/qcrc_checker.sv
// Port-level checks for the quote/comment range classifier, bound to the top level.
// Depends on qcrc_pkg and quote_comment_range_classifier.
`default_nettype none

module qcrc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [15:0] escaped_mask_o,
  input wire logic [15:0] quote_mask_o,
  input wire logic [15:0] comment_mask_o,
  input wire logic [15:0] bound_mask_o,
  input wire logic [15:0] inside_mask_o
);

  // every accepted item comes out under done_o at the end of the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(qcrc_pkg::LATENCY) done_o)
    else $error("item not delivered after pipeline latency");

  // escaped quotes and comment starts never show up as live
  a_no_esc_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (((quote_mask_o | comment_mask_o) & escaped_mask_o) == 16'h0))
    else $error("escaped byte marked as quote or comment start");

  // top inside bit is the parity of all bounds; bottom inside bit equals bound bit 0
  a_inside_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((inside_mask_o[15] == ^bound_mask_o)
                && (inside_mask_o[0] == bound_mask_o[0])))
    else $error("inside mask disagrees with bound parity");

  // nothing precedes byte 0, so it can never be escaped
  a_first_unescaped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !escaped_mask_o[0])
    else $error("byte 0 marked escaped");

endmodule

bind quote_comment_range_classifier qcrc_checker u_qcrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .escaped_mask_o (escaped_mask_o),
  .quote_mask_o   (quote_mask_o),
  .comment_mask_o (comment_mask_o),
  .bound_mask_o   (bound_mask_o),
  .inside_mask_o  (inside_mask_o)
);

`default_nettype wire
